// File: hw/rtl/moving_and_exponential_average_filter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the averaging filter RTL.
// ----------------------------------------------------------------------------
`ifndef MOVING_AND_EXPONENTIAL_AVERAGE_FILTER_DEFINES_SVH
`define MOVING_AND_EXPONENTIAL_AVERAGE_FILTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MAVG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MAVG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/mavg_pkg.sv
// ----------------------------------------------------------------------------
// mavg_pkg
// Types and fixed constants shared by the averaging filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mavg_pkg;

   localparam int CHANNEL_W    = 2;
   localparam int TAG_W        = 32;
   localparam int WINDOW_REG_W = 7;
   localparam int ALPHA_W      = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_MODE      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTHING_WEIGHT = 2'd2;

   localparam logic FILTER_MODE_MA  = 1'b0;
   localparam logic FILTER_MODE_EMA = 1'b1;

   localparam logic [WINDOW_REG_W-1:0] WINDOW_RESET = 7'd20;
   localparam logic [ALPHA_W-1:0]      ALPHA_RESET  = 16'd4588;

   // 1.0 in unsigned Q1.16.
   localparam logic [ALPHA_W:0] ALPHA_ONE = 17'h10000;

   typedef struct packed {
      logic                    mode;
      logic [WINDOW_REG_W-1:0] window;
      logic [ALPHA_W-1:0]      alpha;
      logic                    clear;
   } cfg_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_UPDATE,
      ENG_DIVIDE,
      ENG_SIGN,
      ENG_BLEND,
      ENG_DONE
   } eng_state_type;

endpackage

`default_nettype wire

// File: hw/rtl/moving_and_exponential_average_filter.sv
// ----------------------------------------------------------------------------
// moving_and_exponential_average_filter
// Multichannel moving-average / exponential smoothing filter, Q4.12 samples.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter as beats on a queue-style port: a beat is taken on a rising
// edge where push is high and full is low. Each beat yields exactly one result
// beat, in order, on the result queue: data is valid while empty is low and is
// taken on an edge where pop is high. The csr_ port writes filter mode, window
// length and alpha; it is always ready. Writing mode or window clears the
// history of every channel, so write it only while the block is idle.
// In moving-average mode each item passes through the update, a bit-serial
// divide, a sign step and the result push; in exponential mode it passes
// through the update and a blend step, which use the shared multiplier once
// each, and then the result push. The engine works on one item at a time and
// takes the next input beat only after the result of the last one is pushed,
// so items are taken no faster than the engine finishes them. Two-
// entry queues on each side let the input accept beats and the engine finish
// a result while the receiver stalls; if both result entries are held, the
// engine waits and then the input fills. Synchronous reset restores mode 0,
// window 20, alpha 4588 and clears all channel history; the window memory
// needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_and_exponential_average_filter #(
   parameter int CHANNELS    = 4,
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // configuration write channel
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [mavg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [mavg_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // sample input beats
   input  wire logic                             push,
   output logic                                  full,
   input  wire logic [mavg_pkg::CHANNEL_W-1:0]   req_channel,
   input  wire logic signed [SAMPLE_BITS-1:0]    req_sample,
   input  wire logic [mavg_pkg::TAG_W-1:0]       req_time_tag,
   input  wire logic                             req_restart,
   // filtered result beats
   input  wire logic                             pop,
   output logic                                  empty,
   output logic      [mavg_pkg::CHANNEL_W-1:0]   rsp_out_channel,
   output logic signed [SAMPLE_BITS-1:0]         rsp_filtered,
   output logic      [mavg_pkg::TAG_W-1:0]       rsp_out_time_tag
);

   import mavg_pkg::*;

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   cfg_type                       cfg;
   logic                          item_pop;
   logic                          item_empty;
   logic [CHANNEL_W-1:0]          item_channel;
   logic [CH_W-1:0]               item_idx;
   logic signed [SAMPLE_BITS-1:0] item_sample;
   logic [TAG_W-1:0]              item_tag;
   logic                          item_restart;

   // The front holds the registers, folds the channel number onto the
   // implemented channels and buffers input beats.
   mavg_front #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg),
      .push         (push),
      .full         (full),
      .req_channel  (req_channel),
      .req_sample   (req_sample),
      .req_time_tag (req_time_tag),
      .req_restart  (req_restart),
      .item_pop     (item_pop),
      .item_empty   (item_empty),
      .item_channel (item_channel),
      .item_idx     (item_idx),
      .item_sample  (item_sample),
      .item_tag     (item_tag),
      .item_restart (item_restart)
   );

   // The engine keeps the per-channel history and the raw sample window,
   // computes one filtered value per item and queues the result.
   mavg_engine #(
      .CHANNELS    (CHANNELS),
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .item_pop         (item_pop),
      .item_empty       (item_empty),
      .item_channel     (item_channel),
      .item_idx         (item_idx),
      .item_sample      (item_sample),
      .item_tag         (item_tag),
      .item_restart     (item_restart),
      .pop              (pop),
      .empty            (empty),
      .rsp_out_channel  (rsp_out_channel),
      .rsp_filtered     (rsp_filtered),
      .rsp_out_time_tag (rsp_out_time_tag)
   );

endmodule

`default_nettype wire

// File: hw/rtl/mavg_ram.sv
// ----------------------------------------------------------------------------
// mavg_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: hw/rtl/mavg_fifo.sv
// ----------------------------------------------------------------------------
// mavg_fifo
// Two-entry queue used as the decoupling stage on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_fifo #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  empty
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/mavg_front.sv
// ----------------------------------------------------------------------------
// mavg_front
// Configuration registers, channel classification and the input queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_front #(
   parameter int CHANNELS    = 4,
   parameter int SAMPLE_BITS = 16,
   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // configuration port
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [mavg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [mavg_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output mavg_pkg::cfg_type                     cfg,
   // input channel
   input  wire logic                             push,
   output logic                                  full,
   input  wire logic [mavg_pkg::CHANNEL_W-1:0]   req_channel,
   input  wire logic signed [SAMPLE_BITS-1:0]    req_sample,
   input  wire logic [mavg_pkg::TAG_W-1:0]       req_time_tag,
   input  wire logic                             req_restart,
   // classified items toward the engine
   input  wire logic                             item_pop,
   output logic                                  item_empty,
   output logic      [mavg_pkg::CHANNEL_W-1:0]   item_channel,
   output logic      [CH_W-1:0]                  item_idx,
   output logic signed [SAMPLE_BITS-1:0]         item_sample,
   output logic      [mavg_pkg::TAG_W-1:0]       item_tag,
   output logic                                  item_restart
);

   import mavg_pkg::*;

   localparam int ITEM_W = CHANNEL_W + CH_W + SAMPLE_BITS + TAG_W + 1;

   logic                    mode_ff, mode_in;
   logic [WINDOW_REG_W-1:0] window_ff, window_in;
   logic [ALPHA_W-1:0]      alpha_ff, alpha_in;
   logic                    clear;
   logic [4:0]              ch_fold;
   logic [ITEM_W-1:0]       item_wdata, item_rdata;

   assign csr_ready = 1'b1;

   always_comb begin
      mode_in   = mode_ff;
      window_in = window_ff;
      alpha_in  = alpha_ff;
      clear     = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FILTER_MODE: begin
               mode_in = csr_wdata[0];
               clear   = 1'b1;
            end
            CSR_WINDOW_LENGTH: begin
               window_in = csr_wdata[WINDOW_REG_W-1:0];
               clear     = 1'b1;
            end
            CSR_SMOOTHING_WEIGHT: begin
               alpha_in = csr_wdata[ALPHA_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= FILTER_MODE_MA;
         window_ff <= WINDOW_RESET;
         alpha_ff  <= ALPHA_RESET;
      end else begin
         mode_ff   <= mode_in;
         window_ff <= window_in;
         alpha_ff  <= alpha_in;
      end
   end

   assign cfg.mode   = mode_ff;
   assign cfg.window = window_ff;
   assign cfg.alpha  = alpha_ff;
   assign cfg.clear  = clear;

   // Fold the channel number onto the implemented channels.
   always_comb begin
      ch_fold = {3'b000, req_channel};
      for (int i = 0; i < 3; i++) begin
         if (ch_fold >= 5'(CHANNELS)) begin
            ch_fold = ch_fold - 5'(CHANNELS);
         end
      end
   end

   assign item_wdata = {req_channel, ch_fold[CH_W-1:0], req_sample, req_time_tag, req_restart};

   mavg_fifo #(
      .WIDTH (ITEM_W)
   ) u_item_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (item_wdata),
      .full  (full),
      .pop   (item_pop),
      .rdata (item_rdata),
      .empty (item_empty)
   );

   assign {item_channel, item_idx, item_sample, item_tag, item_restart} = item_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/mavg_engine.sv
// ----------------------------------------------------------------------------
// mavg_engine
// Per-channel filter state, window memory, divider, blend and result queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "moving_and_exponential_average_filter_defines.svh"

module mavg_engine #(
   parameter int CHANNELS    = 4,
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 16,
   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire mavg_pkg::cfg_type              cfg,
   // classified items from the front
   output logic                                item_pop,
   input  wire logic                           item_empty,
   input  wire logic [mavg_pkg::CHANNEL_W-1:0] item_channel,
   input  wire logic [CH_W-1:0]                item_idx,
   input  wire logic signed [SAMPLE_BITS-1:0]  item_sample,
   input  wire logic [mavg_pkg::TAG_W-1:0]     item_tag,
   input  wire logic                           item_restart,
   // result channel
   input  wire logic                           pop,
   output logic                                empty,
   output logic      [mavg_pkg::CHANNEL_W-1:0] rsp_out_channel,
   output logic signed [SAMPLE_BITS-1:0]       rsp_filtered,
   output logic      [mavg_pkg::TAG_W-1:0]     rsp_out_time_tag
);

   import mavg_pkg::*;

   localparam int WP_W    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
   localparam int OW      = CNT_W + 1;
   localparam int CMP_W   = (CNT_W > WINDOW_REG_W) ? CNT_W : WINDOW_REG_W;
   localparam int SUM_W   = SAMPLE_BITS + WP_W;
   localparam int DC_W    = $clog2(SUM_W);
   localparam int ACC_W   = SAMPLE_BITS + 18;
   localparam int RAM_AW  = CH_W + WP_W;
   localparam int RES_W   = CHANNEL_W + SAMPLE_BITS + TAG_W;

   eng_state_type state_ff, state_in;

   // per-channel history
   logic signed [SUM_W-1:0]       sum_ff  [CHANNELS];
   logic        [CNT_W-1:0]       cnt_ff  [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] last_ff [CHANNELS];
   logic        [WP_W-1:0]        wp_ff   [CHANNELS];

   // item being worked on
   logic [CHANNEL_W-1:0]          work_ch_ff;
   logic [CH_W-1:0]               work_idx_ff;
   logic signed [SAMPLE_BITS-1:0] work_x_ff;
   logic [TAG_W-1:0]              work_tag_ff;
   logic signed [SUM_W-1:0]       work_sum_ff;
   logic [CNT_W-1:0]              work_cnt_ff;
   logic [WP_W-1:0]               work_wp_ff;
   logic signed [SAMPLE_BITS-1:0] work_prev_ff;

   // divider and blend
   logic [SUM_W-1:0]              quo_ff;
   logic [CNT_W-1:0]              rem_ff;
   logic [CNT_W-1:0]              divisor_ff;
   logic                          div_neg_ff;
   logic [DC_W-1:0]               div_cnt_ff;
   logic signed [ACC_W-1:0]       acc_ff;
   logic signed [SAMPLE_BITS-1:0] res_ff;

   logic                          ram_we;
   logic [RAM_AW-1:0]             ram_raddr;
   logic [SAMPLE_BITS-1:0]        ram_rdata;
   logic                          out_push;
   logic                          out_full;
   logic [RES_W-1:0]              out_rdata;

   logic [CMP_W-1:0]              win_cmp;
   logic [CNT_W-1:0]              eff_win;
   logic [WP_W-1:0]               cur_wp;
   logic [OW-1:0]                 wp_ext, win_ext, old_ext;
   logic                          full_win;
   logic signed [SAMPLE_BITS-1:0] old_val;
   logic signed [SUM_W-1:0]       new_sum;
   logic [SUM_W-1:0]              sum_abs;
   logic [CNT_W-1:0]              new_cnt;
   logic [WP_W-1:0]               new_wp;
   logic [OW-1:0]                 div_shift;
   logic [OW:0]                   div_trial;
   logic                          div_bit;
   logic [SUM_W-1:0]              quo_neg;
   logic signed [17:0]            mul_a;
   logic signed [SAMPLE_BITS-1:0] mul_b;
   logic signed [ACC_W-1:0]       mul_p;
   logic signed [ACC_W-1:0]       blend_sum;

   // Window length zero acts as one, beyond the memory as the memory size.
   always_comb begin
      win_cmp = CMP_W'(cfg.window);
      if (win_cmp == '0) begin
         eff_win = CNT_W'(1);
      end else if (win_cmp > CMP_W'(WINDOW_MAX)) begin
         eff_win = CNT_W'(WINDOW_MAX);
      end else begin
         eff_win = win_cmp[CNT_W-1:0];
      end
   end

   // Oldest window slot of the incoming item, read while it is captured.
   always_comb begin
      cur_wp  = item_restart ? '0 : wp_ff[item_idx];
      wp_ext  = OW'(cur_wp);
      win_ext = OW'(eff_win);
      if (wp_ext >= win_ext) begin
         old_ext = wp_ext - win_ext;
      end else begin
         old_ext = wp_ext + OW'(WINDOW_MAX) - win_ext;
      end
      ram_raddr = {item_idx, old_ext[WP_W-1:0]};
   end

   // Moving-average update of the captured item.
   always_comb begin
      full_win = (work_cnt_ff >= eff_win);
      old_val  = full_win ? $signed(ram_rdata) : '0;
      new_sum  = work_sum_ff - SUM_W'(old_val) + SUM_W'(work_x_ff);
      new_cnt  = full_win ? eff_win : work_cnt_ff + CNT_W'(1);
      new_wp   = (work_wp_ff == WP_W'(WINDOW_MAX - 1)) ? '0 : work_wp_ff + WP_W'(1);
      sum_abs  = new_sum[SUM_W-1] ? -new_sum : new_sum;
   end

   // One quotient bit per cycle, restoring.
   always_comb begin
      div_shift = {rem_ff, quo_ff[SUM_W-1]};
      div_trial = {1'b0, div_shift} - {2'b00, divisor_ff};
      div_bit   = !div_trial[OW];
      quo_neg   = -quo_ff;
   end

   // Shared multiplier: alpha times sample, then one minus alpha times history.
   always_comb begin
      if (state_ff == ENG_BLEND) begin
         mul_a = $signed({1'b0, ALPHA_ONE - {1'b0, cfg.alpha}});
         mul_b = work_prev_ff;
      end else begin
         mul_a = $signed({2'b00, cfg.alpha});
         mul_b = work_x_ff;
      end
      mul_p     = ACC_W'(mul_a * mul_b);
      blend_sum = acc_ff + mul_p;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ENG_IDLE: begin
            if (!item_empty) state_in = ENG_UPDATE;
         end
         ENG_UPDATE: begin
            state_in = (cfg.mode == FILTER_MODE_EMA) ? ENG_BLEND : ENG_DIVIDE;
         end
         ENG_DIVIDE: begin
            if (div_cnt_ff == '0) state_in = ENG_SIGN;
         end
         ENG_SIGN:  state_in = ENG_DONE;
         ENG_BLEND: state_in = ENG_DONE;
         ENG_DONE: begin
            if (!out_full) state_in = ENG_IDLE;
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      item_pop = 1'b0;
      ram_we   = 1'b0;
      out_push = 1'b0;
      unique case (state_ff)
         ENG_IDLE:   item_pop = !item_empty;
         ENG_UPDATE: ram_we   = (cfg.mode == FILTER_MODE_MA);
         ENG_DONE:   out_push = !out_full;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Channel history: cleared by reset and by a mode or window write.
   always_ff @(posedge clock) begin
      if (reset || cfg.clear) begin
         for (int c = 0; c < CHANNELS; c++) begin
            sum_ff[c]  <= '0;
            cnt_ff[c]  <= '0;
            last_ff[c] <= '0;
            wp_ff[c]   <= '0;
         end
      end else begin
         unique case (state_ff)
            ENG_UPDATE: begin
               if (cfg.mode == FILTER_MODE_MA) begin
                  sum_ff[work_idx_ff] <= new_sum;
                  cnt_ff[work_idx_ff] <= new_cnt;
                  wp_ff[work_idx_ff]  <= new_wp;
               end else begin
                  sum_ff[work_idx_ff] <= work_sum_ff;
                  cnt_ff[work_idx_ff] <= CNT_W'(1);
                  wp_ff[work_idx_ff]  <= work_wp_ff;
               end
            end
            ENG_SIGN: begin
               last_ff[work_idx_ff] <= div_neg_ff ? quo_neg[SAMPLE_BITS-1:0]
                                                  : quo_ff[SAMPLE_BITS-1:0];
            end
            ENG_BLEND: begin
               last_ff[work_idx_ff] <= blend_sum[SAMPLE_BITS+15:16];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (state_ff == ENG_UPDATE) begin
         div_cnt_ff <= DC_W'(SUM_W - 1);
      end else if (state_ff == ENG_DIVIDE) begin
         div_cnt_ff <= div_cnt_ff - DC_W'(1);
      end
   end

   // work registers
   always_ff @(posedge clock) begin
      if (item_pop) begin
         work_ch_ff   <= item_channel;
         work_idx_ff  <= item_idx;
         work_x_ff    <= item_sample;
         work_tag_ff  <= item_tag;
         work_sum_ff  <= item_restart ? '0 : sum_ff[item_idx];
         work_cnt_ff  <= item_restart ? '0 : cnt_ff[item_idx];
         work_wp_ff   <= cur_wp;
         work_prev_ff <= item_restart ? '0 : last_ff[item_idx];
      end
      unique case (state_ff)
         ENG_UPDATE: begin
            quo_ff     <= sum_abs;
            rem_ff     <= '0;
            divisor_ff <= new_cnt;
            div_neg_ff <= new_sum[SUM_W-1];
            acc_ff     <= mul_p;
         end
         ENG_DIVIDE: begin
            rem_ff <= div_bit ? div_trial[CNT_W-1:0] : div_shift[CNT_W-1:0];
            quo_ff <= {quo_ff[SUM_W-2:0], div_bit};
         end
         ENG_SIGN: begin
            res_ff <= div_neg_ff ? quo_neg[SAMPLE_BITS-1:0] : quo_ff[SAMPLE_BITS-1:0];
         end
         ENG_BLEND: begin
            res_ff <= blend_sum[SAMPLE_BITS+15:16];
         end
         default: begin
         end
      endcase
   end

   mavg_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (1 << RAM_AW)
   ) u_window_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr ({work_idx_ff, work_wp_ff}),
      .wdata (work_x_ff),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   mavg_fifo #(
      .WIDTH (RES_W)
   ) u_result_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata ({work_ch_ff, res_ff, work_tag_ff}),
      .full  (out_full),
      .pop   (pop),
      .rdata (out_rdata),
      .empty (empty)
   );

   assign {rsp_out_channel, rsp_filtered, rsp_out_time_tag} = out_rdata;

   `MAVG_ASSERT_NEXT(a_pop_starts_update, clock, reset, item_pop, state_ff == ENG_UPDATE, "item taken but engine did not start")
   `MAVG_ASSERT_NOW(a_push_has_room, clock, reset, out_push, !out_full, "result pushed into a full queue")
   `MAVG_ASSERT_NOW(a_divisor_nonzero, clock, reset, state_ff == ENG_DIVIDE, divisor_ff != '0, "divide by zero count")
   `MAVG_ASSERT_NEXT(a_count_in_window, clock, reset, (state_ff == ENG_UPDATE) && (cfg.mode == FILTER_MODE_MA), cnt_ff[work_idx_ff] <= eff_win, "sample count beyond window")

endmodule

`default_nettype wire
